FILE: hdl/jrsn_pkg.sv
// Shared types, constants and the CRC-32 word update for the journal record scan.
package jrsn_pkg;

  localparam int unsigned RECORDS_PER_SECTOR = 128;
  localparam int unsigned SECTOR_COUNT       = 2;
  localparam int unsigned RING_SLOTS         = RECORDS_PER_SECTOR * SECTOR_COUNT;
  localparam int unsigned SLOT_W             = (RING_SLOTS > 1) ? $clog2(RING_SLOTS) : 1;

  localparam int unsigned WORD_BITS = 32;

  localparam logic [31:0] REC_MAGIC   = 32'h5253_5453;
  localparam logic [15:0] REC_VERSION = 16'h0001;
  localparam logic [31:0] REC_COMMIT  = 32'h0000_0000;
  localparam logic [31:0] CRC_POLY    = 32'hEDB8_8320;
  localparam logic [31:0] CRC_INIT    = 32'hFFFF_FFFF;
  localparam logic [15:0] LIMIT_RESET = 16'd1000;

  typedef logic [2:0] word_idx_t;

  // Word positions inside one 32-byte record.
  localparam word_idx_t WI_MAGIC   = 3'd0;
  localparam word_idx_t WI_VERSION = 3'd1;
  localparam word_idx_t WI_SEQ     = 3'd2;
  localparam word_idx_t WI_TOTAL   = 3'd3;
  localparam word_idx_t WI_PENDING = 3'd4;
  localparam word_idx_t WI_NEXTSEQ = 3'd5;
  localparam word_idx_t WI_CRC     = 3'd6;
  localparam word_idx_t WI_COMMIT  = 3'd7;

  typedef struct packed {
    logic [31:0] word;
    logic        last_word;
  } item_t;

  typedef struct packed {
    logic        found;
    logic [31:0] latest_seq;
    logic [31:0] total_count;
    logic [15:0] remain_ms;
    logic [31:0] pending_cnt;
    logic [31:0] stored_next_sequence;
    logic [7:0]  next_slot;
  } result_t;

  // Reflected CRC-32 over one 32-bit word; the bit loop is a fixed XOR network.
  function automatic logic [31:0] crc_word(logic [31:0] crc, logic [31:0] w);
    logic [31:0] c;
    c = crc ^ w;
    for (int i = 0; i < WORD_BITS; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

FILE: hdl/journal_record_scan_newest_core.sv
// Top level of the journal record scan: finds the newest valid record of a flash ring.
//
// The input channel carries the ring as 32-bit words, eight per record, with
// in_last_word marking the final word of the scan. Each record is checked for
// magic, version, nonzero sequence, remainder below cfg_data's limit, zero
// commit word and a CRC-32 over its first six words; the newest valid one wins.
// On the last word one result transfer appears on the output channel; no other
// word produces a result.
// One word is accepted every cycle while in_stall is low. A word waits in the input
// register and is folded into the scan state when the scan stage advances, which
// also loads the result register, so out_valid rises once the last word has passed
// the input register and the result register. While out_stall holds a waiting result
// the scan stage stops; in_stall is high only then, while the input register is full.
// A synchronous low rst_n clears the scan, empties both registers and sets the
// remainder limit to 1000. The cfg_we write updates the limit; write it only
// while no scan is in progress.
module journal_record_scan_newest_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [15:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] in_word,
  input  logic        in_last_word,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_found,
  output logic [31:0] out_latest_seq,
  output logic [31:0] out_total_count,
  output logic [15:0] out_remain_ms,
  output logic [31:0] out_pending_cnt,
  output logic [31:0] out_stored_next_sequence,
  output logic [7:0]  out_next_slot
);

  logic              advance;
  logic              q_valid;
  jrsn_pkg::item_t   q_item;
  logic              emit;
  jrsn_pkg::result_t scan_result;
  jrsn_pkg::result_t out_result;

  jrsn_in_stage u_in_stage (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_word      (in_word),
    .in_last_word (in_last_word),
    .advance      (advance),
    .q_valid      (q_valid),
    .q_item       (q_item)
  );

  jrsn_scan u_scan (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .fire     (q_valid && advance),
    .item     (q_item),
    .emit     (emit),
    .result   (scan_result)
  );

  jrsn_out_stage u_out_stage (
    .clk        (clk),
    .rst_n      (rst_n),
    .emit       (emit),
    .result     (scan_result),
    .advance    (advance),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_result (out_result)
  );

  assign out_found                = out_result.found;
  assign out_latest_seq           = out_result.latest_seq;
  assign out_total_count          = out_result.total_count;
  assign out_remain_ms            = out_result.remain_ms;
  assign out_pending_cnt          = out_result.pending_cnt;
  assign out_stored_next_sequence = out_result.stored_next_sequence;
  assign out_next_slot            = out_result.next_slot;

endmodule

FILE: hdl/jrsn_in_stage.sv
// Input register stage: holds one accepted journal word until the scan logic takes it.
module jrsn_in_stage (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  input  logic [31:0]     in_word,
  input  logic            in_last_word,
  input  logic            advance,
  output logic            q_valid,
  output jrsn_pkg::item_t q_item
);

  logic            valid_r, valid_nxt;
  jrsn_pkg::item_t item_r, item_nxt;
  logic            accept;

  assign in_stall = valid_r && !advance;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    valid_nxt = valid_r;
    item_nxt  = item_r;
    if (accept) begin
      valid_nxt      = 1'b1;
      item_nxt.word      = in_word;
      item_nxt.last_word = in_last_word;
    end else if (advance) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r <= item_nxt;
  end

  assign q_valid = valid_r;
  assign q_item  = item_r;

endmodule

FILE: hdl/jrsn_scan.sv
// Record checker and newest-record tracker: one journal word is folded in per cycle while fire is high.
module jrsn_scan (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [15:0]       cfg_data,
  input  logic              fire,
  input  jrsn_pkg::item_t   item,
  output logic              emit,
  output jrsn_pkg::result_t result
);

  localparam int unsigned SW = jrsn_pkg::SLOT_W;

  logic [15:0]           limit_r;
  jrsn_pkg::word_idx_t   idx_r, idx_nxt;
  logic [SW-1:0]         slot_r, slot_nxt;
  logic [31:0]           crc_r, crc_nxt;
  logic                  ok_r, ok_nxt;
  logic [31:0]           cur_seq_r, cur_seq_nxt;
  logic [31:0]           cur_total_r, cur_total_nxt;
  logic [31:0]           cur_pend_r, cur_pend_nxt;
  logic [31:0]           cur_nseq_r, cur_nseq_nxt;
  logic [15:0]           cur_rem_r, cur_rem_nxt;
  logic                  found_r, found_nxt;
  logic [31:0]           new_seq_r, new_seq_nxt;
  logic [31:0]           new_total_r, new_total_nxt;
  logic [31:0]           new_pend_r, new_pend_nxt;
  logic [31:0]           new_nseq_r, new_nseq_nxt;
  logic [15:0]           new_rem_r, new_rem_nxt;
  logic [SW-1:0]         new_slot_r, new_slot_nxt;

  logic [31:0]           w;
  logic [31:0]           seq_diff;
  logic                  is_newer;
  logic [SW:0]           slot_inc;
  logic [SW:0]           nslot_inc;
  logic [SW-1:0]         next_slot_w;
  logic [31:0]           next_slot_ext;

  assign w        = item.word;
  assign seq_diff = cur_seq_r - new_seq_r;
  // Serial number arithmetic: newer when the forward distance is nonzero and under half range.
  assign is_newer = (seq_diff != 32'd0) && !seq_diff[31];

  always_comb begin
    idx_nxt       = idx_r;
    slot_nxt      = slot_r;
    crc_nxt       = crc_r;
    ok_nxt        = ok_r;
    cur_seq_nxt   = cur_seq_r;
    cur_total_nxt = cur_total_r;
    cur_pend_nxt  = cur_pend_r;
    cur_nseq_nxt  = cur_nseq_r;
    cur_rem_nxt   = cur_rem_r;
    found_nxt     = found_r;
    new_seq_nxt   = new_seq_r;
    new_total_nxt = new_total_r;
    new_pend_nxt  = new_pend_r;
    new_nseq_nxt  = new_nseq_r;
    new_rem_nxt   = new_rem_r;
    new_slot_nxt  = new_slot_r;
    slot_inc      = {1'b0, slot_r} + 1'b1;
    nslot_inc     = '0;
    next_slot_w   = '0;
    next_slot_ext = '0;
    emit          = 1'b0;
    result        = '0;

    if (fire) begin
      case (idx_r)
        jrsn_pkg::WI_MAGIC: begin
          if (w != jrsn_pkg::REC_MAGIC) ok_nxt = 1'b0;
        end
        jrsn_pkg::WI_VERSION: begin
          if (w[15:0] != jrsn_pkg::REC_VERSION) ok_nxt = 1'b0;
          cur_rem_nxt = w[31:16];
          if (w[31:16] >= limit_r) ok_nxt = 1'b0;
        end
        jrsn_pkg::WI_SEQ: begin
          cur_seq_nxt = w;
          if (w == 32'd0) ok_nxt = 1'b0;
        end
        jrsn_pkg::WI_TOTAL: begin
          cur_total_nxt = w;
        end
        jrsn_pkg::WI_PENDING: begin
          cur_pend_nxt = w;
        end
        jrsn_pkg::WI_NEXTSEQ: begin
          cur_nseq_nxt = w;
        end
        jrsn_pkg::WI_CRC: begin
          if (w != ~crc_r) ok_nxt = 1'b0;
        end
        default: begin
          if (w != jrsn_pkg::REC_COMMIT) ok_nxt = 1'b0;
        end
      endcase

      if (idx_r != jrsn_pkg::WI_CRC && idx_r != jrsn_pkg::WI_COMMIT) begin
        crc_nxt = jrsn_pkg::crc_word(crc_r, w);
      end

      if (idx_r == jrsn_pkg::WI_COMMIT) begin
        if (ok_nxt && (!found_r || is_newer)) begin
          new_seq_nxt   = cur_seq_r;
          new_total_nxt = cur_total_r;
          new_pend_nxt  = cur_pend_r;
          new_nseq_nxt  = cur_nseq_r;
          new_rem_nxt   = cur_rem_r;
          new_slot_nxt  = slot_r;
          found_nxt     = 1'b1;
        end
        slot_nxt      = (32'(slot_inc) >= jrsn_pkg::RING_SLOTS) ? '0 : slot_inc[SW-1:0];
        idx_nxt       = jrsn_pkg::WI_MAGIC;
        crc_nxt       = jrsn_pkg::CRC_INIT;
        ok_nxt        = 1'b1;
        cur_seq_nxt   = '0;
        cur_total_nxt = '0;
        cur_pend_nxt  = '0;
        cur_nseq_nxt  = '0;
        cur_rem_nxt   = '0;
      end else begin
        idx_nxt = idx_r + 3'd1;
      end

      if (item.last_word) begin
        emit = 1'b1;
        nslot_inc   = {1'b0, new_slot_nxt} + 1'b1;
        next_slot_w = (32'(nslot_inc) >= jrsn_pkg::RING_SLOTS) ? '0 : nslot_inc[SW-1:0];
        next_slot_ext = 32'(next_slot_w);
        if (found_nxt) begin
          result.found                = 1'b1;
          result.latest_seq           = new_seq_nxt;
          result.total_count          = new_total_nxt;
          result.remain_ms            = new_rem_nxt;
          result.pending_cnt          = new_pend_nxt;
          result.stored_next_sequence = new_nseq_nxt;
          result.next_slot            = next_slot_ext[7:0];
        end else begin
          result.stored_next_sequence = 32'd1;
        end
        // A partial record at the end of the scan is dropped with the rest of the state.
        idx_nxt       = jrsn_pkg::WI_MAGIC;
        slot_nxt      = '0;
        crc_nxt       = jrsn_pkg::CRC_INIT;
        ok_nxt        = 1'b1;
        cur_seq_nxt   = '0;
        cur_total_nxt = '0;
        cur_pend_nxt  = '0;
        cur_nseq_nxt  = '0;
        cur_rem_nxt   = '0;
        found_nxt     = 1'b0;
        new_seq_nxt   = '0;
        new_total_nxt = '0;
        new_pend_nxt  = '0;
        new_nseq_nxt  = '0;
        new_rem_nxt   = '0;
        new_slot_nxt  = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r     <= jrsn_pkg::LIMIT_RESET;
      idx_r       <= jrsn_pkg::WI_MAGIC;
      slot_r      <= '0;
      crc_r       <= jrsn_pkg::CRC_INIT;
      ok_r        <= 1'b1;
      cur_seq_r   <= '0;
      cur_total_r <= '0;
      cur_pend_r  <= '0;
      cur_nseq_r  <= '0;
      cur_rem_r   <= '0;
      found_r     <= 1'b0;
      new_seq_r   <= '0;
      new_total_r <= '0;
      new_pend_r  <= '0;
      new_nseq_r  <= '0;
      new_rem_r   <= '0;
      new_slot_r  <= '0;
    end else begin
      if (cfg_we) begin
        limit_r <= cfg_data;
      end
      idx_r       <= idx_nxt;
      slot_r      <= slot_nxt;
      crc_r       <= crc_nxt;
      ok_r        <= ok_nxt;
      cur_seq_r   <= cur_seq_nxt;
      cur_total_r <= cur_total_nxt;
      cur_pend_r  <= cur_pend_nxt;
      cur_nseq_r  <= cur_nseq_nxt;
      cur_rem_r   <= cur_rem_nxt;
      found_r     <= found_nxt;
      new_seq_r   <= new_seq_nxt;
      new_total_r <= new_total_nxt;
      new_pend_r  <= new_pend_nxt;
      new_nseq_r  <= new_nseq_nxt;
      new_rem_r   <= new_rem_nxt;
      new_slot_r  <= new_slot_nxt;
    end
  end

endmodule

FILE: hdl/jrsn_out_stage.sv
// Result register: holds one scan result until the receiver takes the transfer.
module jrsn_out_stage (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              emit,
  input  jrsn_pkg::result_t result,
  output logic              advance,
  output logic              out_valid,
  input  logic              out_stall,
  output jrsn_pkg::result_t out_result
);

  logic              valid_r, valid_nxt;
  jrsn_pkg::result_t res_r, res_nxt;

  // The scan stage may move whenever the result register is empty or being drained.
  assign advance = !(valid_r && out_stall);

  always_comb begin
    valid_nxt = valid_r;
    res_nxt   = res_r;
    if (emit) begin
      valid_nxt = 1'b1;
      res_nxt   = result;
    end else if (valid_r && !out_stall) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
  end

  assign out_valid  = valid_r;
  assign out_result = res_r;

endmodule
